>>> hw/rtl/fdhs_pkg.sv
// shared constants, status codes and queue entry type of the fuzzy double hash set
// no dependencies
`default_nettype none

package fdhs_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = 6;
  localparam int unsigned ValW     = 64;

  localparam logic [CntW-1:0] HalfCap = CntW'(Capacity / 2);

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActDump   = 2'd1;
  localparam logic [1:0] ActClear  = 2'd2;

  typedef enum logic [2:0] {
    StInserted = 3'd0,
    StDup      = 3'd1,
    StFull     = 3'd2,
    StEntry    = 3'd3,
    StEmpty    = 3'd4,
    StCleared  = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]      act;
    logic [ValW-1:0] value;
  } cmd_t;

  // closeness bound: rounded |a-b| < 1e-5 holds exactly when the exact difference
  // is at most NearK * 2^-70 (the tie there rounds down to even)
  localparam logic [53:0] NearK    = 54'h29F16B11C6D1E1;
  localparam logic [10:0] ExpMax   = 11'h7FF;
  localparam logic [10:0] ExpPivot = 11'd1008;

endpackage

`default_nettype wire

>>> hw/rtl/fdhs_req_if.sv
// request channel of the fuzzy double hash set
// depends on fdhs_pkg
`default_nettype none

interface fdhs_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [fdhs_pkg::ValW-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fdhs_rsp_if.sv
// result channel of the fuzzy double hash set
// depends on fdhs_pkg
`default_nettype none

interface fdhs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [fdhs_pkg::ValW-1:0] out_value;
  logic [fdhs_pkg::CntW-1:0] entry_count;
  logic                      last;

  modport source (output valid, status, out_value, entry_count, last, input ready);
  modport sink   (input valid, status, out_value, entry_count, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fdhs_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module fdhs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fdhs_near.sv
// three stage closeness test of two doubles: |a - b| < 1e-5 as the rounded double
// difference decides it; depends on fdhs_pkg
`default_nettype none

module fdhs_near (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [fdhs_pkg::ValW-1:0] a_i,
  input  wire logic [fdhs_pkg::ValW-1:0] b_i,
  output logic                           done_o,
  output logic                           near_o
);
  import fdhs_pkg::*;

  // stage 1: order by magnitude, align the smaller operand
  logic        swap;
  logic [63:0] hi, lo;
  logic [10:0] hexp, lexp, ea, eb, dexp;
  logic [52:0] ma, mb;
  logic [55:0] mb8, bsh;
  logic        sticky;

  always_comb begin
    swap = b_i[62:0] > a_i[62:0];
    hi   = swap ? b_i : a_i;
    lo   = swap ? a_i : b_i;
    hexp = hi[62:52];
    lexp = lo[62:52];
    ea   = (hexp == 11'd0) ? 11'd1 : hexp;
    eb   = (lexp == 11'd0) ? 11'd1 : lexp;
    ma   = {hexp != 11'd0, hi[51:0]};
    mb   = {lexp != 11'd0, lo[51:0]};
    dexp = ea - eb;
    mb8  = {mb, 3'b000};
    if (dexp >= 11'd56) begin
      bsh    = '0;
      sticky = |mb8;
    end else begin
      bsh    = mb8 >> dexp[5:0];
      sticky = |(mb8 & ~({56{1'b1}} << dexp[5:0]));
    end
  end

  logic        v1_q, v2_q;
  logic [55:0] ma8_q, bsh_q;
  logic        sticky1_q, sub1_q, spec1_q, far1_q;
  logic [10:0] ea1_q;
  logic [57:0] x_q;
  logic        sticky2_q, sub2_q, spec2_q, far2_q;
  logic [10:0] ea2_q;

  // stage 3 compare against the bound scaled to the units of x
  logic        near;
  logic [10:0] sh;
  logic [57:0] k2;

  always_comb begin
    sh   = '0;
    k2   = '0;
    near = 1'b0;
    if (spec2_q) begin
      near = 1'b0;
    end else if (ea2_q >= ExpPivot) begin
      sh = ea2_q - ExpPivot;
      if (far2_q) begin
        near = 1'b0;
      end else if (sh >= 11'd54) begin
        near = (x_q == '0);
      end else begin
        near = x_q <= {4'b0000, NearK >> sh[5:0]};
      end
    end else begin
      sh = ExpPivot - ea2_q;
      if (sh >= 11'd5) begin
        near = 1'b1;
      end else begin
        k2 = {4'b0000, NearK} << sh[2:0];
        // truncated bits of the smaller operand only matter for a sum at the bound
        near = sub2_q ? (x_q <= k2) : ((x_q < k2) || ((x_q == k2) && !sticky2_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      done_o    <= 1'b0;
      near_o    <= 1'b0;
      ma8_q     <= '0;
      bsh_q     <= '0;
      sticky1_q <= 1'b0;
      sub1_q    <= 1'b0;
      spec1_q   <= 1'b0;
      far1_q    <= 1'b0;
      ea1_q     <= '0;
      x_q       <= '0;
      sticky2_q <= 1'b0;
      sub2_q    <= 1'b0;
      spec2_q   <= 1'b0;
      far2_q    <= 1'b0;
      ea2_q     <= '0;
    end else begin
      v1_q      <= start_i;
      ma8_q     <= {ma, 3'b000};
      bsh_q     <= bsh;
      sticky1_q <= sticky;
      sub1_q    <= hi[63] == lo[63];
      spec1_q   <= (hexp == ExpMax) || (lexp == ExpMax);
      far1_q    <= dexp >= 11'd3;
      ea1_q     <= ea;

      v2_q      <= v1_q;
      x_q       <= sub1_q ? ({2'b00, ma8_q} - {2'b00, bsh_q})
                          : ({2'b00, ma8_q} + {2'b00, bsh_q});
      sticky2_q <= sticky1_q;
      sub2_q    <= sub1_q;
      spec2_q   <= spec1_q;
      far2_q    <= far1_q;
      ea2_q     <= ea1_q;

      done_o    <= v2_q;
      near_o    <= near;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fdhs_front.sv
// front end: accepts requests, drops unused action codes, queues commands (2 deep)
// depends on fdhs_pkg and fdhs_req_if
`default_nettype none

module fdhs_front (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fdhs_req_if.sink    req_i,
  output logic        cmd_valid_o,
  output fdhs_pkg::cmd_t cmd_o,
  input  wire logic   cmd_pop_i
);
  import fdhs_pkg::*;

  cmd_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       accept, push, pop;

  assign req_i.ready = cnt_q != 2'd2;
  assign accept      = req_i.valid && req_i.ready;
  assign push        = accept && ((req_i.action == ActInsert) || (req_i.action == ActDump) ||
                                  (req_i.action == ActClear));
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = ent_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) begin
        ent_q[wptr_q] <= '{act: req_i.action, value: req_i.value};
        wptr_q        <= ~wptr_q;
      end
      if (pop) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fdhs_back.sv
// back end: probe sequencer, dump sweep, occupancy bits and result register
// depends on fdhs_pkg, fdhs_rsp_if, fdhs_ram and fdhs_near
`default_nettype none

module fdhs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_valid_i,
  input  wire fdhs_pkg::cmd_t  cmd_i,
  output logic                 cmd_pop_o,
  fdhs_rsp_if.source           rsp_o
);
  import fdhs_pkg::*;

  typedef enum logic [2:0] {
    BIdle, BProbe, BRead, BCmp, BResult, BScan, BDumpRd, BDumpOut
  } state_e;

  state_e              state_q;
  logic [Capacity-1:0] occ_q;
  logic [CntW-1:0]     count_q, n_q;
  logic [ValW-1:0]     v_q, dval_q;
  logic [IdxW-1:0]     slot_q, t_q, i_q;
  status_e             res_q;

  logic                out_valid_q, out_last_q;
  status_e             out_status_q;
  logic [ValW-1:0]     out_value_q;
  logic [CntW-1:0]     out_count_q;

  logic                can_load, out_load, ram_we, ram_re;
  logic [IdxW-1:0]     ram_raddr;
  logic [ValW-1:0]     ram_rdata;
  logic                cmp_done, cmp_near;

  assign can_load  = !out_valid_q || rsp_o.ready;
  assign out_load  = can_load && ((state_q == BResult) || (state_q == BDumpOut));
  assign cmd_pop_o = state_q == BIdle;
  assign ram_we    = (state_q == BProbe) && !occ_q[slot_q] && (count_q < HalfCap);
  assign ram_re    = (state_q == BProbe) || (state_q == BScan);
  assign ram_raddr = (state_q == BScan) ? i_q : slot_q;

  fdhs_ram #(
    .Width (ValW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (v_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fdhs_near u_near (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == BRead),
    .a_i     (v_q),
    .b_i     (ram_rdata),
    .done_o  (cmp_done),
    .near_o  (cmp_near)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.out_value   = out_value_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.last        = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BIdle;
      occ_q        <= '0;
      count_q      <= '0;
      n_q          <= '0;
      v_q          <= '0;
      dval_q       <= '0;
      slot_q       <= '0;
      t_q          <= '0;
      i_q          <= '0;
      res_q        <= StInserted;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_status_q <= StInserted;
      out_value_q  <= '0;
      out_count_q  <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && !rsp_o.ready);
      unique case (state_q)
        BIdle: begin
          if (cmd_valid_i) begin
            priority case (cmd_i.act)
              ActInsert: begin
                v_q     <= cmd_i.value;
                slot_q  <= cmd_i.value[IdxW-1:0];
                t_q     <= '0;
                state_q <= BProbe;
              end
              ActDump: begin
                if (count_q == '0) begin
                  res_q   <= StEmpty;
                  state_q <= BResult;
                end else begin
                  i_q     <= '0;
                  n_q     <= '0;
                  state_q <= BScan;
                end
              end
              default: begin
                // only clear reaches here, the front drops unused codes
                occ_q   <= '0;
                count_q <= '0;
                res_q   <= StCleared;
                state_q <= BResult;
              end
            endcase
          end
        end
        BProbe: begin
          if (!occ_q[slot_q]) begin
            if (count_q >= HalfCap) begin
              res_q <= StFull;
            end else begin
              occ_q[slot_q] <= 1'b1;
              count_q       <= count_q + CntW'(1);
              res_q         <= StInserted;
            end
            state_q <= BResult;
          end else begin
            state_q <= BRead;
          end
        end
        BRead: begin
          state_q <= BCmp;
        end
        BCmp: begin
          if (cmp_done) begin
            if (cmp_near) begin
              res_q   <= StDup;
              state_q <= BResult;
            end else if (t_q == IdxW'(Capacity - 1)) begin
              res_q   <= StFull;
              state_q <= BResult;
            end else begin
              // triangular step: next offset grows by t + 1
              t_q     <= t_q + IdxW'(1);
              slot_q  <= slot_q + t_q + IdxW'(1);
              state_q <= BProbe;
            end
          end
        end
        BResult: begin
          if (can_load) begin
            out_status_q <= res_q;
            out_value_q  <= '0;
            out_count_q  <= count_q;
            out_last_q   <= 1'b1;
            state_q      <= BIdle;
          end
        end
        BScan: begin
          if (occ_q[i_q]) begin
            state_q <= BDumpRd;
          end else begin
            i_q <= i_q + IdxW'(1);
          end
        end
        BDumpRd: begin
          dval_q  <= ram_rdata;
          state_q <= BDumpOut;
        end
        BDumpOut: begin
          if (can_load) begin
            out_status_q <= StEntry;
            out_value_q  <= dval_q;
            out_count_q  <= count_q;
            out_last_q   <= n_q == count_q - CntW'(1);
            if (n_q == count_q - CntW'(1)) begin
              state_q <= BIdle;
            end else begin
              n_q     <= n_q + CntW'(1);
              i_q     <= i_q + IdxW'(1);
              state_q <= BScan;
            end
          end
        end
        default: begin
          state_q <= BIdle;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/fuzzy_double_hash_set.sv
// insert: the command passes through the command queue, then each occupied slot probed
//   takes a ram read and the 3 stage closeness test, before the result is decided and registered
// dump: sweeps the slots and reads out each stored entry; clear: resets occupancy and count
// one command at a time in the back end; the 2 deep queue keeps the request side open
// reset clears occupancy bits, entry count, queue and result register; no clearing pass
// depends on fdhs_pkg, fdhs_req_if, fdhs_rsp_if, fdhs_front and fdhs_back
`default_nettype none

module fuzzy_double_hash_set (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fdhs_req_if.sink  req_i,
  fdhs_rsp_if.source rsp_o
);
  import fdhs_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  fdhs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  fdhs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
